// ===== rtl/tccr_pkg.sv =====
// ----------------------------------------------------------------------------
// tccr_pkg
// Shared types, codes and the 5x7 font for the text console cell renderer.
// ----------------------------------------------------------------------------
package tccr_pkg;

    localparam int COLUMNS_DEF        = 40;
    localparam int ROWS_ON_SCREEN_DEF = 20;
    localparam int TAB_STOP_DEF       = 4;

    localparam logic [7:0] CHR_BEL     = 8'h07;
    localparam logic [7:0] CHR_BS      = 8'h08;
    localparam logic [7:0] CHR_TAB     = 8'h09;
    localparam logic [7:0] CHR_LF      = 8'h0A;
    localparam logic [7:0] CHR_FF      = 8'h0C;
    localparam logic [7:0] CHR_CR      = 8'h0D;
    localparam logic [7:0] GLYPH_FIRST = 8'h20;
    localparam logic [7:0] GLYPH_LAST  = 8'h7E;

    typedef enum logic [1:0] {
        CMD_DRAW   = 2'd0,
        CMD_SCROLL = 2'd1,
        CMD_CLEAR  = 2'd2
    } t_cmd_kind;

    typedef logic [0:6][4:0] t_glyph;
    typedef logic [0:7][4:0] t_cell;

    typedef struct packed {
        logic       clear;
        logic [1:0] scrolls;
        logic       draw;
        logic [5:0] col;
        logic [4:0] row;
        t_cell      rows;
    } t_plan;

    localparam t_glyph BOX_GLYPH = '{5'h1F, 5'h11, 5'h15, 5'h11, 5'h15, 5'h11, 5'h1F};

    localparam t_glyph FONT_ROM [95] = '{
        '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h00,5'h04},
        '{5'h0A,5'h0A,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h0A,5'h0A,5'h1F,5'h0A,5'h1F,5'h0A,5'h0A},
        '{5'h04,5'h0F,5'h14,5'h0E,5'h05,5'h1E,5'h04}, '{5'h18,5'h19,5'h02,5'h04,5'h08,5'h13,5'h03},
        '{5'h08,5'h14,5'h14,5'h08,5'h15,5'h12,5'h0D}, '{5'h04,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00},
        '{5'h02,5'h04,5'h08,5'h08,5'h08,5'h04,5'h02}, '{5'h08,5'h04,5'h02,5'h02,5'h02,5'h04,5'h08},
        '{5'h00,5'h04,5'h15,5'h0E,5'h15,5'h04,5'h00}, '{5'h00,5'h04,5'h04,5'h1F,5'h04,5'h04,5'h00},
        '{5'h00,5'h00,5'h00,5'h00,5'h0C,5'h04,5'h08}, '{5'h00,5'h00,5'h00,5'h1F,5'h00,5'h00,5'h00},
        '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h0C,5'h0C}, '{5'h01,5'h01,5'h02,5'h04,5'h08,5'h10,5'h10},
        '{5'h0E,5'h11,5'h13,5'h15,5'h19,5'h11,5'h0E}, '{5'h04,5'h0C,5'h04,5'h04,5'h04,5'h04,5'h0E},
        '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h08,5'h1F}, '{5'h1F,5'h02,5'h04,5'h02,5'h01,5'h11,5'h0E},
        '{5'h02,5'h06,5'h0A,5'h12,5'h1F,5'h02,5'h02}, '{5'h1F,5'h10,5'h1E,5'h01,5'h01,5'h11,5'h0E},
        '{5'h06,5'h08,5'h10,5'h1E,5'h11,5'h11,5'h0E}, '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h08,5'h08},
        '{5'h0E,5'h11,5'h11,5'h0E,5'h11,5'h11,5'h0E}, '{5'h0E,5'h11,5'h11,5'h0F,5'h01,5'h02,5'h0C},
        '{5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h0C,5'h00}, '{5'h00,5'h0C,5'h0C,5'h00,5'h0C,5'h04,5'h08},
        '{5'h02,5'h04,5'h08,5'h10,5'h08,5'h04,5'h02}, '{5'h00,5'h00,5'h1F,5'h00,5'h1F,5'h00,5'h00},
        '{5'h08,5'h04,5'h02,5'h01,5'h02,5'h04,5'h08}, '{5'h0E,5'h11,5'h01,5'h02,5'h04,5'h00,5'h04},
        '{5'h0E,5'h11,5'h01,5'h0D,5'h15,5'h15,5'h0E}, '{5'h0E,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11},
        '{5'h1E,5'h11,5'h11,5'h1E,5'h11,5'h11,5'h1E}, '{5'h0E,5'h11,5'h10,5'h10,5'h10,5'h11,5'h0E},
        '{5'h1C,5'h12,5'h11,5'h11,5'h11,5'h12,5'h1C}, '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h1F},
        '{5'h1F,5'h10,5'h10,5'h1E,5'h10,5'h10,5'h10}, '{5'h0E,5'h11,5'h10,5'h17,5'h11,5'h11,5'h0F},
        '{5'h11,5'h11,5'h11,5'h1F,5'h11,5'h11,5'h11}, '{5'h0E,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E},
        '{5'h07,5'h02,5'h02,5'h02,5'h02,5'h12,5'h0C}, '{5'h11,5'h12,5'h14,5'h18,5'h14,5'h12,5'h11},
        '{5'h10,5'h10,5'h10,5'h10,5'h10,5'h10,5'h1F}, '{5'h11,5'h1B,5'h15,5'h15,5'h11,5'h11,5'h11},
        '{5'h11,5'h11,5'h19,5'h15,5'h13,5'h11,5'h11}, '{5'h0E,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        '{5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10,5'h10}, '{5'h0E,5'h11,5'h11,5'h11,5'h15,5'h12,5'h0D},
        '{5'h1E,5'h11,5'h11,5'h1E,5'h14,5'h12,5'h11}, '{5'h0F,5'h10,5'h10,5'h0E,5'h01,5'h01,5'h1E},
        '{5'h1F,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}, '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h11,5'h0E},
        '{5'h11,5'h11,5'h11,5'h11,5'h11,5'h0A,5'h04}, '{5'h11,5'h11,5'h11,5'h15,5'h15,5'h15,5'h0A},
        '{5'h11,5'h11,5'h0A,5'h04,5'h0A,5'h11,5'h11}, '{5'h11,5'h11,5'h0A,5'h04,5'h04,5'h04,5'h04},
        '{5'h1F,5'h01,5'h02,5'h04,5'h08,5'h10,5'h1F}, '{5'h0E,5'h08,5'h08,5'h08,5'h08,5'h08,5'h0E},
        '{5'h10,5'h10,5'h08,5'h04,5'h02,5'h01,5'h01}, '{5'h0E,5'h02,5'h02,5'h02,5'h02,5'h02,5'h0E},
        '{5'h04,5'h0A,5'h11,5'h00,5'h00,5'h00,5'h00}, '{5'h00,5'h00,5'h00,5'h00,5'h00,5'h00,5'h1F},
        '{5'h08,5'h04,5'h00,5'h00,5'h00,5'h00,5'h00}, '{5'h00,5'h00,5'h0E,5'h01,5'h0F,5'h11,5'h0F},
        '{5'h10,5'h10,5'h1E,5'h11,5'h11,5'h11,5'h1E}, '{5'h00,5'h00,5'h0E,5'h11,5'h10,5'h11,5'h0E},
        '{5'h01,5'h01,5'h0F,5'h11,5'h11,5'h11,5'h0F}, '{5'h00,5'h00,5'h0E,5'h11,5'h1F,5'h10,5'h0E},
        '{5'h06,5'h09,5'h08,5'h1C,5'h08,5'h08,5'h08}, '{5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h0E},
        '{5'h10,5'h10,5'h16,5'h19,5'h11,5'h11,5'h11}, '{5'h04,5'h00,5'h0C,5'h04,5'h04,5'h04,5'h0E},
        '{5'h02,5'h00,5'h06,5'h02,5'h02,5'h12,5'h0C}, '{5'h10,5'h10,5'h12,5'h14,5'h18,5'h14,5'h12},
        '{5'h0C,5'h04,5'h04,5'h04,5'h04,5'h04,5'h0E}, '{5'h00,5'h00,5'h1A,5'h15,5'h15,5'h15,5'h15},
        '{5'h00,5'h00,5'h16,5'h19,5'h11,5'h11,5'h11}, '{5'h00,5'h00,5'h0E,5'h11,5'h11,5'h11,5'h0E},
        '{5'h00,5'h1E,5'h11,5'h11,5'h1E,5'h10,5'h10}, '{5'h00,5'h0F,5'h11,5'h11,5'h0F,5'h01,5'h01},
        '{5'h00,5'h00,5'h16,5'h19,5'h10,5'h10,5'h10}, '{5'h00,5'h00,5'h0F,5'h10,5'h0E,5'h01,5'h1E},
        '{5'h08,5'h08,5'h1C,5'h08,5'h08,5'h09,5'h06}, '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h13,5'h0D},
        '{5'h00,5'h00,5'h11,5'h11,5'h11,5'h0A,5'h04}, '{5'h00,5'h00,5'h11,5'h11,5'h15,5'h15,5'h0A},
        '{5'h00,5'h00,5'h11,5'h0A,5'h04,5'h0A,5'h11}, '{5'h00,5'h11,5'h11,5'h11,5'h0F,5'h01,5'h0E},
        '{5'h00,5'h00,5'h1F,5'h02,5'h04,5'h08,5'h1F}, '{5'h02,5'h04,5'h04,5'h08,5'h04,5'h04,5'h02},
        '{5'h04,5'h04,5'h04,5'h04,5'h04,5'h04,5'h04}, '{5'h08,5'h04,5'h04,5'h02,5'h04,5'h04,5'h08},
        '{5'h00,5'h00,5'h08,5'h15,5'h02,5'h00,5'h00}
    };

endpackage

// ===== rtl/tccr_decode.sv =====
// ----------------------------------------------------------------------------
// tccr_decode
// Cursor registers and per-byte decode into a command plan.
// ----------------------------------------------------------------------------
module tccr_decode
    import tccr_pkg::*;
#(
    parameter int COLUMNS        = COLUMNS_DEF,
    parameter int ROWS_ON_SCREEN = ROWS_ON_SCREEN_DEF,
    parameter int TAB_STOP       = TAB_STOP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_character,
    output t_plan      o_plan,
    output logic       o_empty
);

    localparam logic [5:0] COLS_W = 6'(COLUMNS);
    localparam logic [5:0] ROWS_W = 6'(ROWS_ON_SCREEN);
    localparam logic [5:0] TAB_W  = 6'(TAB_STOP);

    logic [5:0] r_col;
    logic [4:0] r_row;
    logic [5:0] n_col;
    logic [4:0] n_row;
    logic [6:0] tab_tbl [64];

    // next tab stop for every column value
    for (genvar v = 0; v < 64; v++) begin : g_tab
        assign tab_tbl[v] = 7'(((v / TAB_STOP) + 1) * TAB_STOP);
    end

    always_comb begin
        logic [5:0] c;
        logic [4:0] r;
        logic [1:0] s;
        logic [6:0] stop;
        logic [7:0] off;
        t_glyph     g;
        c       = r_col;
        r       = r_row;
        s       = 2'd0;
        stop    = 7'd0;
        off     = 8'(i_character - GLYPH_FIRST);
        g       = BOX_GLYPH;
        o_plan  = '0;
        unique case (i_character)
            CHR_LF: begin
                c = 6'd0;
                if (6'({1'b0, r} + 6'd1) < ROWS_W) begin
                    r = 5'(r + 5'd1);
                end else begin
                    s = 2'd1;
                end
            end
            CHR_CR: begin
                c = 6'd0;
            end
            CHR_BS: begin
                if (c != 6'd0) begin
                    c = 6'(c - 6'd1);
                end
            end
            CHR_BEL: begin
            end
            CHR_FF: begin
                o_plan.clear = 1'b1;
                c = 6'd0;
                r = 5'd0;
            end
            CHR_TAB: begin
                if (c >= COLS_W) begin
                    c = 6'd0;
                    if (6'({1'b0, r} + 6'd1) < ROWS_W) begin
                        r = 5'(r + 5'd1);
                    end else begin
                        s = 2'(s + 2'd1);
                    end
                end
                stop = tab_tbl[c];
                if (stop <= {1'b0, COLS_W}) begin
                    c = stop[5:0];
                end else if (TAB_STOP <= COLUMNS) begin
                    c = TAB_W;
                    if (6'({1'b0, r} + 6'd1) < ROWS_W) begin
                        r = 5'(r + 5'd1);
                    end else begin
                        s = 2'(s + 2'd1);
                    end
                end else begin
                    c = COLS_W;
                end
            end
            default: begin
                if (i_character >= GLYPH_FIRST && i_character <= GLYPH_LAST) begin
                    g = FONT_ROM[off[6:0]];
                end
                if (c >= COLS_W) begin
                    c = 6'd0;
                    if (6'({1'b0, r} + 6'd1) < ROWS_W) begin
                        r = 5'(r + 5'd1);
                    end else begin
                        s = 2'd1;
                    end
                end
                o_plan.draw = 1'b1;
                o_plan.col  = c;
                o_plan.row  = r;
                o_plan.rows = {g, 5'h00};
                c = 6'(c + 6'd1);
            end
        endcase
        o_plan.scrolls = s;
        n_col = c;
        n_row = r;
    end

    assign o_empty = !o_plan.clear && (o_plan.scrolls == 2'd0) && !o_plan.draw;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= 6'd0;
            r_row <= 5'd0;
        end else if (i_accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/tccr_emitter.sv =====
// ----------------------------------------------------------------------------
// tccr_emitter
// Plan register, command sequencer and output register.
// ----------------------------------------------------------------------------
module tccr_emitter
    import tccr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_load,
    input  t_plan      i_plan,
    output logic       o_plan_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_command_kind,
    output logic [5:0] o_cell_column,
    output logic [4:0] o_cell_row,
    output logic [2:0] o_scanline,
    output logic [5:0] o_pixel_mask,
    output logic       o_last
);

    logic       r_busy;
    t_plan      r_plan;
    logic [2:0] r_line;
    logic       r_out_valid;
    logic [1:0] r_kind;
    logic [5:0] r_col;
    logic [4:0] r_row;
    logic [2:0] r_scan;
    logic [5:0] r_mask;
    logic       r_last;

    t_cmd_kind  n_kind;
    logic [5:0] n_col;
    logic [4:0] n_row;
    logic [2:0] n_scan;
    logic [5:0] n_mask;
    logic       n_last;
    logic       step;

    assign step         = r_busy && (!r_out_valid || i_out_ready);
    assign o_plan_ready = !r_busy || (step && n_last);

    always_comb begin
        n_kind = CMD_DRAW;
        n_col  = 6'd0;
        n_row  = 5'd0;
        n_scan = 3'd0;
        n_mask = 6'd0;
        n_last = 1'b0;
        if (r_plan.clear) begin
            n_kind = CMD_CLEAR;
            n_last = (r_plan.scrolls == 2'd0) && !r_plan.draw;
        end else if (r_plan.scrolls != 2'd0) begin
            n_kind = CMD_SCROLL;
            n_last = (r_plan.scrolls == 2'd1) && !r_plan.draw;
        end else begin
            n_kind = CMD_DRAW;
            n_col  = r_plan.col;
            n_row  = r_plan.row;
            n_scan = r_line;
            n_mask = {r_plan.rows[r_line], 1'b0};
            n_last = (r_line == 3'd7);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (i_load) begin
            r_busy <= 1'b1;
        end else if (step && n_last) begin
            r_busy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_plan <= i_plan;
            r_line <= 3'd0;
        end else if (step) begin
            if (r_plan.clear) begin
                r_plan.clear <= 1'b0;
            end else if (r_plan.scrolls != 2'd0) begin
                r_plan.scrolls <= 2'(r_plan.scrolls - 2'd1);
            end else begin
                r_line <= 3'(r_line + 3'd1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (step) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_kind <= n_kind;
            r_col  <= n_col;
            r_row  <= n_row;
            r_scan <= n_scan;
            r_mask <= n_mask;
            r_last <= n_last;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_command_kind = r_kind;
    assign o_cell_column  = r_col;
    assign o_cell_row     = r_row;
    assign o_scanline     = r_scan;
    assign o_pixel_mask   = r_mask;
    assign o_last         = r_last;

endmodule

// ===== rtl/text_console_cell_renderer.sv =====
// ----------------------------------------------------------------------------
// text_console_cell_renderer
// Terminal-style byte console that turns each byte into cell drawing,
// scroll and clear commands for a 6x8 pixel character grid.
// ----------------------------------------------------------------------------
//  channel | signals                          | payload
//  --------+----------------------------------+----------------------------------
//  input   | i_in_valid / o_in_ready          | i_character
//  output  | o_out_valid / i_out_ready        | o_command_kind, o_cell_column,
//          |                                  | o_cell_row, o_scanline,
//          |                                  | o_pixel_mask, o_last
//
//  one command leaves per cycle while the output is not stalled; a drawn byte
//  gives 8 or 9 commands, a tab or line feed 0 or 1, form feed 1, BEL, CR and BS 0
//  the command sequencer with its single plan register sets the rate
//  a new item is taken in the cycle its predecessor emits its last command
//  reset clears the cursor to column 0, row 0 and drops pending commands
//  a stall on the output holds the output register and the sequencer
// ----------------------------------------------------------------------------
module text_console_cell_renderer
    import tccr_pkg::*;
#(
    parameter int COLUMNS        = COLUMNS_DEF,
    parameter int ROWS_ON_SCREEN = ROWS_ON_SCREEN_DEF,
    parameter int TAB_STOP       = TAB_STOP_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    input  logic [7:0] i_character,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic [1:0] o_command_kind,
    output logic [5:0] o_cell_column,
    output logic [4:0] o_cell_row,
    output logic [2:0] o_scanline,
    output logic [5:0] o_pixel_mask,
    output logic       o_last
);

    t_plan plan;
    logic  plan_empty;
    logic  plan_ready;
    logic  accept;

    assign o_in_ready = plan_ready;
    assign accept     = i_in_valid && plan_ready;

    tccr_decode #(
        .COLUMNS        (COLUMNS),
        .ROWS_ON_SCREEN (ROWS_ON_SCREEN),
        .TAB_STOP       (TAB_STOP)
    ) u_decode (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_character (i_character),
        .o_plan      (plan),
        .o_empty     (plan_empty)
    );

    tccr_emitter u_emitter (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (accept && !plan_empty),
        .i_plan         (plan),
        .o_plan_ready   (plan_ready),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_command_kind (o_command_kind),
        .o_cell_column  (o_cell_column),
        .o_cell_row     (o_cell_row),
        .o_scanline     (o_scanline),
        .o_pixel_mask   (o_pixel_mask),
        .o_last         (o_last)
    );

endmodule
